### sv/button_press_classifier_defines.svh
// assertion helpers used by the classifier top module
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bpc_pkg.sv
package bpc_pkg;

	localparam int CFG_WIDTH = 16;

	// register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_LONG     = 2'd1;
	localparam logic [1:0] REG_WINDOW   = 2'd2;
	localparam logic [1:0] REG_POLARITY = 2'd3;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_SHORT   = 3'd1,
		EV_LONG    = 3'd2,
		EV_TIMEOUT = 3'd3,
		EV_CONFIRM = 3'd4
	} event_t;

	// debounced level and its edges for the tick being processed
	typedef struct packed {
		logic level;
		logic rise;
		logic fall;
	} level_info_t;

endpackage

### sv/bpc_debounce.sv
module bpc_debounce
	import bpc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 raw,
	input  logic [CFG_WIDTH-1:0] debounce_ticks,
	output level_info_t          info
);

	localparam int CmpWidth = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	logic                   prev_raw_q;
	logic                   stable_q;
	logic [COUNT_WIDTH-1:0] stable_cnt_q;
	logic [COUNT_WIDTH-1:0] stable_cnt_next;
	logic                   stable_next;

	always_comb begin
		if (raw != prev_raw_q) begin
			stable_cnt_next = '0;
		end else if (&stable_cnt_q) begin
			stable_cnt_next = stable_cnt_q;
		end else begin
			stable_cnt_next = stable_cnt_q + 1'b1;
		end
		if (CmpWidth'(stable_cnt_next) >= CmpWidth'(debounce_ticks)) begin
			stable_next = raw;
		end else begin
			stable_next = stable_q;
		end
		info.level = stable_next;
		info.rise  = stable_next & ~stable_q;
		info.fall  = ~stable_next & stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q   <= 1'b0;
			stable_q     <= 1'b0;
			stable_cnt_q <= '0;
		end else if (step) begin
			prev_raw_q   <= raw;
			stable_q     <= stable_next;
			stable_cnt_q <= stable_cnt_next;
		end
	end

endmodule

### sv/bpc_fsm.sv
module bpc_fsm
	import bpc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  level_info_t          info,
	input  logic [CFG_WIDTH-1:0] long_press_ticks,
	input  logic [CFG_WIDTH-1:0] confirm_window_ticks,
	output event_t               event_code,
	output logic [CFG_WIDTH-1:0] window_remaining
);

	localparam int CmpWidth = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	typedef enum logic [1:0] {
		IDLE,
		PRESSED,
		LONG_HELD,
		WINDOW
	} mode_t;

	mode_t                  mode_q, mode_next;
	logic [COUNT_WIDTH-1:0] hold_cnt_q, hold_cnt_next;
	logic [COUNT_WIDTH-1:0] win_cnt_q, win_cnt_next;
	logic [COUNT_WIDTH-1:0] hold_inc, win_inc;
	logic [CmpWidth-1:0]    win_ext, win_cfg_ext;

	assign hold_inc    = (&hold_cnt_q) ? hold_cnt_q : hold_cnt_q + 1'b1;
	assign win_inc     = (&win_cnt_q) ? win_cnt_q : win_cnt_q + 1'b1;
	assign win_ext     = CmpWidth'(win_cnt_next);
	assign win_cfg_ext = CmpWidth'(confirm_window_ticks);

	always_comb begin
		mode_next     = mode_q;
		hold_cnt_next = hold_cnt_q;
		win_cnt_next  = win_cnt_q;
		event_code    = EV_NONE;
		case (mode_q)
			IDLE: begin
				if (info.rise) begin
					mode_next     = PRESSED;
					hold_cnt_next = '0;
				end
			end
			PRESSED: begin
				hold_cnt_next = hold_inc;
				if (info.fall) begin
					mode_next  = IDLE;
					event_code = EV_SHORT;
				end else if (info.level &&
				             CmpWidth'(hold_inc) >= CmpWidth'(long_press_ticks)) begin
					mode_next  = LONG_HELD;
					event_code = EV_LONG;
				end
			end
			LONG_HELD: begin
				if (info.fall) begin
					mode_next    = WINDOW;
					win_cnt_next = '0;
				end
			end
			WINDOW: begin
				win_cnt_next = win_inc;
				if (CmpWidth'(win_inc) >= win_cfg_ext) begin
					mode_next  = IDLE;
					event_code = EV_TIMEOUT;
				end else if (info.fall) begin
					mode_next  = IDLE;
					event_code = EV_CONFIRM;
				end
			end
			default: begin
				mode_next = IDLE;
			end
		endcase
		// remaining is below the 16-bit threshold, so truncation is exact
		if (mode_next == WINDOW && win_ext < win_cfg_ext) begin
			window_remaining = CFG_WIDTH'(win_cfg_ext - win_ext);
		end else begin
			window_remaining = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= IDLE;
			hold_cnt_q <= '0;
			win_cnt_q  <= '0;
		end else if (step) begin
			mode_q     <= mode_next;
			hold_cnt_q <= hold_cnt_next;
			win_cnt_q  <= win_cnt_next;
		end
	end

endmodule

### sv/button_press_classifier.sv
// Button debounce and press classifier.
// Input stream: one word per millisecond tick, s_tdata[0] is the raw pin level.
// Output stream: one word per tick: event code, debounced pressed level and
// ticks left in the confirm window (zero while the window is closed).
// Configuration: cfg_we/cfg_addr/cfg_wdata writes debounce ticks, long press
// ticks, confirm window ticks and pin polarity; write only while idle.
// Pipeline: a tick accepted is registered in the input stage, and its result
// is registered in the output register once the output has room.
// Throughput: one tick per cycle unless the output stalls; all counters and
// the four-state machine update between the input and output registers.
// Stall: when m_tready is low the result holds; the input stage still takes
// one more word, then s_tready drops until the output drains.
// Reset: clears the pipeline, returns the registers to their defaults and
// assumes a released button with all counters at zero.
module button_press_classifier
	import bpc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pin_level, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] event_code, [3] pressed_level,
	                               // [19:4] window_remaining, [23:20] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	`include "button_press_classifier_defines.svh"

	logic [CFG_WIDTH-1:0] debounce_ticks_q;
	logic [CFG_WIDTH-1:0] long_press_ticks_q;
	logic [CFG_WIDTH-1:0] confirm_window_ticks_q;
	logic                 active_high_q;

	logic                 valid_s1;
	logic                 pin_s1;
	logic                 advance;
	logic                 raw;
	level_info_t          info;
	event_t               event_code;
	logic [CFG_WIDTH-1:0] window_remaining;

	logic                 m_valid_q;
	event_t               event_s2;
	logic                 level_s2;
	logic [CFG_WIDTH-1:0] remain_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q       <= 16'd50;
			long_press_ticks_q     <= 16'd5000;
			confirm_window_ticks_q <= 16'd10000;
			active_high_q          <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DEBOUNCE: debounce_ticks_q       <= cfg_wdata;
				REG_LONG:     long_press_ticks_q     <= cfg_wdata;
				REG_WINDOW:   confirm_window_ticks_q <= cfg_wdata;
				REG_POLARITY: active_high_q          <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign raw      = active_high_q ? pin_s1 : ~pin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pin_s1 <= s_tdata[0];
		end
	end

	bpc_debounce #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.raw            (raw),
		.debounce_ticks (debounce_ticks_q),
		.info           (info)
	);

	bpc_fsm #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_fsm (
		.clk                  (clk),
		.arst_n               (arst_n),
		.step                 (advance),
		.info                 (info),
		.long_press_ticks     (long_press_ticks_q),
		.confirm_window_ticks (confirm_window_ticks_q),
		.event_code           (event_code),
		.window_remaining     (window_remaining)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2  <= event_code;
			level_s2  <= info.level;
			remain_s2 <= window_remaining;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, remain_s2, level_s2, event_s2};

	// an event always leaves the confirm window closed
	`BPC_ASSERT_NOW(a_event_closes_window,
		m_valid_q && event_s2 != EV_NONE, remain_s2 == '0,
		"window open on an event word")

	// a long hold is only reported while the button is held
	`BPC_ASSERT_NOW(a_long_while_pressed,
		m_valid_q && event_s2 == EV_LONG, level_s2,
		"long hold reported with button released")

	// a word in the input stage with room downstream reaches the output
	`BPC_ASSERT_NEXT(a_stage_moves, advance, m_valid_q,
		"input stage word lost")

	// remaining ticks never exceed the configured window
	`BPC_ASSERT_NOW(a_remain_bound, m_valid_q, remain_s2 <= confirm_window_ticks_q,
		"window remaining above configured length")

endmodule

### sim/tb_button_press_classifier.sv
module tb_button_press_classifier;
	import bpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_PRESSED,
		MODE_LONG,
		MODE_WINDOW
	} press_mode_t;

	typedef struct packed {
		event_t      ev;
		logic        level;
		logic [15:0] remaining;
	} tick_result_t;

	localparam logic [15:0] COUNT_MAX = 16'hffff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] pin_level, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [2:0] event_code, [3] pressed_level,
	                               // [19:4] window_remaining, [23:20] zero
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = 2'd0;
	logic [15:0] cfg_wdata = 16'd0;

	// configuration copy seen by the classifier model
	logic [15:0] cfg_debounce;
	logic [15:0] cfg_long;
	logic [15:0] cfg_window;
	logic        cfg_active_high;

	// classifier model state
	press_mode_t fsm_mode;
	logic        db_prev;
	logic        db_level;
	logic [15:0] db_count;
	logic [15:0] hold_count;
	logic [15:0] win_count;

	logic         pin_pending[$];
	tick_result_t tick_results[$];
	int           errors = 0;
	int           queued = 0;
	logic         no_idle = 1'b0;

	button_press_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic tick_result_t classify_tick(logic pin);
		logic         raw;
		logic         was;
		logic         rise;
		logic         fall;
		tick_result_t r;
		raw = cfg_active_high ? pin : ~pin;
		was = db_level;
		r.ev = EV_NONE;
		r.remaining = 16'd0;
		if (raw != db_prev) begin
			db_count = 16'd0;
			db_prev = raw;
		end else begin
			db_count = sat_inc(db_count);
		end
		if (db_count >= cfg_debounce)
			db_level = raw;
		rise = db_level && !was;
		fall = !db_level && was;
		case (fsm_mode)
			MODE_IDLE: begin
				if (rise) begin
					fsm_mode = MODE_PRESSED;
					hold_count = 16'd0;
				end
			end
			MODE_PRESSED: begin
				hold_count = sat_inc(hold_count);
				if (fall) begin
					fsm_mode = MODE_IDLE;
					r.ev = EV_SHORT;
				end else if (db_level && hold_count >= cfg_long) begin
					fsm_mode = MODE_LONG;
					r.ev = EV_LONG;
				end
			end
			MODE_LONG: begin
				if (fall) begin
					fsm_mode = MODE_WINDOW;
					win_count = 16'd0;
				end
			end
			default: begin
				win_count = sat_inc(win_count);
				// timeout wins over a release on the same tick
				if (win_count >= cfg_window) begin
					fsm_mode = MODE_IDLE;
					r.ev = EV_TIMEOUT;
				end else if (fall) begin
					fsm_mode = MODE_IDLE;
					r.ev = EV_CONFIRM;
				end
			end
		endcase
		if (fsm_mode == MODE_WINDOW && win_count < cfg_window)
			r.remaining = cfg_window - win_count;
		r.level = db_level;
		return r;
	endfunction

	// driver: offers queued pin levels, one word per tick
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				tick_results.push_back(classify_tick(s_tdata[0]));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 && !no_idle) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 11) == 0) begin
					gap_left = $urandom_range(0, 11);
					s_tvalid <= 1'b0;
				end else if (pin_pending.size() > 0) begin
					s_tdata <= {7'd0, pin_pending.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result word against the oldest prediction
	int           stall_left = 0;
	int           results_seen = 0;
	bit           long_hold_done = 1'b0;
	tick_result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (tick_results.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
					errors++;
				end else begin
					want = tick_results.pop_front();
					if (m_tdata[2:0] !== want.ev) begin
						$display("%0t: event_code expected %0d actual %0d",
							$time, want.ev, m_tdata[2:0]);
						errors++;
					end
					if (m_tdata[3] !== want.level) begin
						$display("%0t: pressed_level expected %0d actual %0d",
							$time, want.level, m_tdata[3]);
						errors++;
					end
					if (m_tdata[19:4] !== want.remaining) begin
						$display("%0t: window_remaining expected %0d actual %0d",
							$time, want.remaining, m_tdata[19:4]);
						errors++;
					end
				end
			end
			if (stall_left > 0 && !no_idle) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 200 && pin_pending.size() > 20) begin
				// long back-pressure so the input side fills and stalls
				long_hold_done = 1'b1;
				stall_left = 79;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_DEBOUNCE: cfg_debounce = val;
			REG_LONG:     cfg_long = val;
			REG_WINDOW:   cfg_window = val;
			REG_POLARITY: cfg_active_high = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(int db, int lp, int cw, bit ah);
		write_reg(REG_DEBOUNCE, db[15:0]);
		write_reg(REG_LONG, lp[15:0]);
		write_reg(REG_WINDOW, cw[15:0]);
		write_reg(REG_POLARITY, {15'd0, ah});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pin_pending.size() > 0 || s_tvalid || tick_results.size() > 0);
	endtask

	task automatic push_pin(logic pin);
		pin_pending.push_back(pin);
		queued++;
	endtask

	// a few bouncing ticks, then a steady pressed or released level
	task automatic add_run(logic pressed, int n, int bounce);
		for (int i = 0; i < bounce; i++)
			push_pin(1'($urandom_range(0, 1)));
		for (int i = 0; i < n; i++)
			push_pin(cfg_active_high ? pressed : ~pressed);
	endtask

	task automatic queue_gesture();
		int db;
		int lp;
		int cw;
		int kind;
		db = cfg_debounce > 20 ? 20 : int'(cfg_debounce);
		lp = cfg_long > 200 ? 200 : int'(cfg_long);
		cw = cfg_window > 60 ? 64 : int'(cfg_window) + 4;
		kind = $urandom_range(0, 9);
		if (kind <= 2) begin
			add_run(1'b1, db + 1 + $urandom_range(0, lp > 1 ? lp - 1 : 0), $urandom_range(0, 3));
			add_run(1'b0, db + 1 + $urandom_range(0, 4), $urandom_range(0, 3));
		end else if (kind <= 6) begin
			// long hold, release, then a second press inside or past the window
			add_run(1'b1, db + lp + $urandom_range(1, 4), $urandom_range(0, 3));
			add_run(1'b0, db + $urandom_range(1, cw), $urandom_range(0, 3));
			add_run(1'b1, db + $urandom_range(1, 4), $urandom_range(0, 3));
			add_run(1'b0, db + $urandom_range(2, 6), $urandom_range(0, 3));
		end else if (kind == 7) begin
			for (int i = $urandom_range(1, 16); i > 0; i--)
				push_pin(1'($urandom_range(0, 1)));
		end else if (kind == 8) begin
			add_run(1'b1, db + lp + 2, 0);
			add_run(1'b0, db + cw + 4, 0);
		end else begin
			// glitch shorter than the debounce time
			add_run(1'b1, $urandom_range(0, db), 0);
			add_run(1'b0, db + 2, 0);
		end
	endtask

	task automatic run_phase(int n_items);
		queued = 0;
		while (queued < n_items)
			queue_gesture();
		wait_drained();
	endtask

	initial begin
		cfg_debounce = 16'd50;
		cfg_long = 16'd5000;
		cfg_window = 16'd10000;
		cfg_active_high = 1'b0;
		fsm_mode = MODE_IDLE;
		db_prev = 1'b0;
		db_level = 1'b0;
		db_count = 16'd0;
		hold_count = 16'd0;
		win_count = 16'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: active low, a press held past the debounce time
		@(negedge clk);
		add_run(1'b1, 70, 0);
		add_run(1'b0, 70, 3);
		wait_drained();

		// short press, long hold, confirm, then window timeout
		configure(0, 2, 3, 1'b1);
		@(negedge clk);
		push_pin(1'b1); push_pin(1'b0); push_pin(1'b1); push_pin(1'b1); push_pin(1'b1);
		push_pin(1'b0); push_pin(1'b1); push_pin(1'b0); push_pin(1'b1); push_pin(1'b1);
		push_pin(1'b1); push_pin(1'b0); push_pin(1'b0); push_pin(1'b0); push_pin(1'b0);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			configure(int'($urandom_range(0, 6)), int'($urandom_range(0, 30)),
				int'($urandom_range(0, 40)), 1'($urandom_range(0, 1)));
			@(negedge clk);
			run_phase(40);
		end

		configure(0, 0, 0, 1'b0);
		@(negedge clk);
		run_phase(30);

		configure(0, 5, 65535, 1'b1);
		@(negedge clk);
		run_phase(40);

		configure(65535, 65535, 65535, 1'b1);
		@(negedge clk);
		for (int i = 0; i < 40; i++)
			push_pin(1'($urandom_range(0, 1)));
		wait_drained();

		configure(int'($urandom_range(0, 4)), int'($urandom_range(1, 20)),
			int'($urandom_range(1, 30)), 1'b0);
		@(negedge clk);
		no_idle = 1'b1;
		run_phase(60);

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
